// ===== rtl/stsm_pkg.sv =====
package stsm_pkg;

  localparam int N_SRC      = 3;
  localparam int ACTION_W   = 2;
  localparam int MODE_W     = 2;
  localparam int SEV_W      = 2;
  localparam int THR_W      = 32;
  localparam int MASK_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_JOINT = 2'd0,
    ACT_ODOM  = 2'd1,
    ACT_IMU   = 2'd2,
    ACT_EVAL  = 2'd3
  } action_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_DRY_RUN = 2'd0,
    MODE_SHADOW  = 2'd1,
    MODE_ACTIVE  = 2'd2
  } mode_t;

  typedef enum logic [SEV_W-1:0] {
    SEV_OK      = 2'd0,
    SEV_WARN    = 2'd1,
    SEV_PASSIVE = 2'd2
  } severity_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_JOINT_TIMEOUT = 3'd0,
    REG_ODOM_TIMEOUT  = 3'd1,
    REG_IMU_TIMEOUT   = 3'd2,
    REG_SKEW_WARN     = 3'd3,
    REG_SKEW_PASSIVE  = 3'd4,
    REG_CAL_VERIFIED  = 3'd5,
    REG_ALLOW_MASK    = 3'd6
  } reg_idx_t;

  localparam logic [THR_W-1:0]  TIMEOUT_RESET      = 32'd100000;
  localparam logic [THR_W-1:0]  SKEW_WARN_RESET    = 32'd10000;
  localparam logic [THR_W-1:0]  SKEW_PASSIVE_RESET = 32'd20000;
  localparam logic [MASK_W-1:0] ALLOW_MASK_RESET   = 3'b011;

  // Pair order: joint-odom, joint-imu, odom-imu
  localparam logic [1:0] PAIR_A [N_SRC] = '{2'd0, 2'd0, 2'd1};
  localparam logic [1:0] PAIR_B [N_SRC] = '{2'd1, 2'd2, 2'd2};

  typedef struct packed {
    logic              rejected;
    severity_t         severity;
    logic              complete;
    logic [MASK_W-1:0] missing_mask;
    logic [MASK_W-1:0] stale_mask;
    logic [MASK_W-1:0] future_mask;
    logic [MASK_W-1:0] skew_warn_mask;
    logic [MASK_W-1:0] skew_passive_mask;
    logic              mode_granted;
    logic              blocked_by_passive;
    logic              blocked_by_calibration;
  } result_t;

endpackage

// ===== rtl/stsm_if.sv =====
interface stsm_in_if #(
  parameter int TIME_WIDTH = 48
);
  import stsm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ACTION_W-1:0]   action;
  logic [TIME_WIDTH-1:0] stamp_us;
  logic                  snapshot_ok;
  logic [MODE_W-1:0]     requested_mode;

  modport source (output valid, action, stamp_us, snapshot_ok, requested_mode,
                  input ready);
  modport sink   (input valid, action, stamp_us, snapshot_ok, requested_mode,
                  output ready);
endinterface

interface stsm_out_if;
  import stsm_pkg::*;

  logic              valid;
  logic              ready;
  logic              rejected;
  logic [SEV_W-1:0]  severity;
  logic              complete;
  logic [MASK_W-1:0] missing_mask;
  logic [MASK_W-1:0] stale_mask;
  logic [MASK_W-1:0] future_mask;
  logic [MASK_W-1:0] skew_warn_mask;
  logic [MASK_W-1:0] skew_passive_mask;
  logic              mode_granted;
  logic              blocked_by_passive;
  logic              blocked_by_calibration;

  modport source (output valid, rejected, severity, complete, missing_mask, stale_mask,
                  future_mask, skew_warn_mask, skew_passive_mask, mode_granted,
                  blocked_by_passive, blocked_by_calibration,
                  input ready);
  modport sink   (input valid, rejected, severity, complete, missing_mask, stale_mask,
                  future_mask, skew_warn_mask, skew_passive_mask, mode_granted,
                  blocked_by_passive, blocked_by_calibration,
                  output ready);
endinterface

interface stsm_cfg_if;
  import stsm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/sensor_timestamp_sync_monitor_top.sv =====
// Sensor timestamp sync monitor. Tracks the latest stamp and a present flag for the
// joint, odometry and inertial sources. Update items (action 0..2) store the stamp of
// their source unless snapshot_ok is low, in which case the item is rejected and no
// state changes. Evaluate items (action 3) take stamp_us as the current time and report
// missing, stale and future-stamped sources, pairwise skew against the warn and passive
// thresholds (only once all three sources are present), a severity and the mode gating.
// Every item gives exactly one result item. Throughput is one item per clock unless the
// result slot is still held by an earlier result. The accepting edge loads the input
// register; the evaluated result then moves into the result register as soon as the
// result slot is free or being emptied. The stamp store is read and written in the
// evaluation stage, so each item sees every earlier update. Stamps wrap modulo
// 2^TIME_WIDTH, and the item channel's stamp width must equal TIME_WIDTH. The
// configuration port is always ready; write it only while the block is idle.
// Thresholds are used as written (passive_dt >= warn_dt and nonzero timeouts are up to
// software).
module sensor_timestamp_sync_monitor_top #(
  parameter int TIME_WIDTH = 48
) (
  input logic         clk,
  input logic         rst,
  stsm_in_if.sink     item,
  stsm_out_if.source  result,
  stsm_cfg_if.sink    cfg
);
  import stsm_pkg::*;

  // Configuration registers
  logic [THR_W-1:0]  timeout [N_SRC];
  logic [THR_W-1:0]  skew_warn;
  logic [THR_W-1:0]  skew_passive;
  logic              cal_verified;
  logic [MASK_W-1:0] allow_mask;

  // Input register
  logic                  q_valid;
  action_t               q_action;
  logic [TIME_WIDTH-1:0] q_stamp;
  logic                  q_ok;
  logic [MODE_W-1:0]     q_mode;

  // Per-source state
  logic [N_SRC-1:0]      present;
  logic [TIME_WIDTH-1:0] stamp [N_SRC];

  // Result register
  logic    r_valid;
  result_t r_data;

  logic    advance;
  logic    store_en;
  result_t res_next;

  // Move the held item into the result register when the result slot is free or
  // being emptied this cycle; the input register refills in the same cycle.
  assign advance    = q_valid && (!r_valid || result.ready);
  assign item.ready = !q_valid || advance;
  assign store_en   = advance && (q_action != ACT_EVAL) && q_ok;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout[0]   <= TIMEOUT_RESET;
      timeout[1]   <= TIMEOUT_RESET;
      timeout[2]   <= TIMEOUT_RESET;
      skew_warn    <= SKEW_WARN_RESET;
      skew_passive <= SKEW_PASSIVE_RESET;
      cal_verified <= 1'b0;
      allow_mask   <= ALLOW_MASK_RESET;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_JOINT_TIMEOUT: timeout[0]   <= cfg.data;
        REG_ODOM_TIMEOUT:  timeout[1]   <= cfg.data;
        REG_IMU_TIMEOUT:   timeout[2]   <= cfg.data;
        REG_SKEW_WARN:     skew_warn    <= cfg.data;
        REG_SKEW_PASSIVE:  skew_passive <= cfg.data;
        REG_CAL_VERIFIED:  cal_verified <= cfg.data[0];
        REG_ALLOW_MASK:    allow_mask   <= cfg.data[MASK_W-1:0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  // Input register: hold the item until it moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      q_action <= action_t'(item.action);
      q_stamp  <= item.stamp_us;
      q_ok     <= item.snapshot_ok;
      q_mode   <= item.requested_mode;
    end
  end

  // Source state: update the stamp and present flag of an accepted snapshot
  always_ff @(posedge clk) begin
    if (rst) begin
      present  <= '0;
      stamp[0] <= '0;
      stamp[1] <= '0;
      stamp[2] <= '0;
    end else if (store_en) begin
      present[q_action[1:0]] <= 1'b1;
      stamp[q_action[1:0]]   <= q_stamp;
    end
  end

  // Evaluation logic
  always_comb begin
    logic [N_SRC-1:0]      present_after;
    logic [TIME_WIDTH-1:0] age;
    logic [TIME_WIDTH-1:0] d_ab;
    logic [TIME_WIDTH-1:0] d_ba;
    logic [TIME_WIDTH-1:0] skew;
    logic [MASK_W-1:0]     stale;
    logic [MASK_W-1:0]     future;
    logic [MASK_W-1:0]     swarn;
    logic [MASK_W-1:0]     spass;
    logic                  passive;
    logic                  bp;
    logic                  bc;

    present_after = present;
    age     = '0;
    d_ab    = '0;
    d_ba    = '0;
    skew    = '0;
    stale   = '0;
    future  = '0;
    swarn   = '0;
    spass   = '0;
    passive = 1'b0;
    bp      = 1'b0;
    bc      = 1'b0;
    res_next = '0;

    if (q_action != ACT_EVAL) begin
      if (q_ok) begin
        present_after[q_action[1:0]] = 1'b1;
      end
      res_next.rejected = !q_ok;
      res_next.complete = &present_after;
    end else begin
      // Freshness per source: a future stamp excludes staleness
      for (int i = 0; i < N_SRC; i++) begin
        age = q_stamp - stamp[i];
        if (present[i]) begin
          if (stamp[i] > q_stamp) begin
            future[i] = 1'b1;
          end else if (age > TIME_WIDTH'(timeout[i])) begin
            stale[i] = 1'b1;
          end
        end
      end

      // Pairwise skew, only once every source has reported
      if (&present) begin
        for (int p = 0; p < N_SRC; p++) begin
          d_ab = stamp[PAIR_A[p]] - stamp[PAIR_B[p]];
          d_ba = stamp[PAIR_B[p]] - stamp[PAIR_A[p]];
          skew = (stamp[PAIR_A[p]] >= stamp[PAIR_B[p]]) ? d_ab : d_ba;
          if (skew > TIME_WIDTH'(skew_passive)) begin
            spass[p] = 1'b1;
          end else if (skew > TIME_WIDTH'(skew_warn)) begin
            swarn[p] = 1'b1;
          end
        end
      end

      passive = (|(~present)) || (|stale) || (|future) || (|spass);
      bp = (q_mode == MODE_ACTIVE) && passive;

      // Calibration gate: an undefined mode is never allowed while unverified
      bc = 1'b0;
      if (!cal_verified) begin
        case (mode_t'(q_mode))
          MODE_DRY_RUN: bc = !allow_mask[0];
          MODE_SHADOW:  bc = !allow_mask[1];
          MODE_ACTIVE:  bc = !allow_mask[2];
          default:      bc = 1'b1;
        endcase
      end

      res_next.severity               = passive ? SEV_PASSIVE : ((|swarn) ? SEV_WARN : SEV_OK);
      res_next.complete               = &present;
      res_next.missing_mask           = ~present;
      res_next.stale_mask             = stale;
      res_next.future_mask            = future;
      res_next.skew_warn_mask         = swarn;
      res_next.skew_passive_mask      = spass;
      res_next.mode_granted           = !bp && !bc;
      res_next.blocked_by_passive     = bp;
      res_next.blocked_by_calibration = bc;
    end
  end

  // Result register: load on advance, release once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (advance) begin
      r_valid <= 1'b1;
    end else if (result.ready) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      r_data <= res_next;
    end
  end

  assign result.valid                  = r_valid;
  assign result.rejected               = r_data.rejected;
  assign result.severity               = r_data.severity;
  assign result.complete               = r_data.complete;
  assign result.missing_mask           = r_data.missing_mask;
  assign result.stale_mask             = r_data.stale_mask;
  assign result.future_mask            = r_data.future_mask;
  assign result.skew_warn_mask         = r_data.skew_warn_mask;
  assign result.skew_passive_mask      = r_data.skew_passive_mask;
  assign result.mode_granted           = r_data.mode_granted;
  assign result.blocked_by_passive     = r_data.blocked_by_passive;
  assign result.blocked_by_calibration = r_data.blocked_by_calibration;

endmodule

// ===== dv/sensor_timestamp_sync_monitor_top_tb.sv =====
module sensor_timestamp_sync_monitor_top_tb;
  import stsm_pkg::*;

  localparam int TW = 48;
  localparam logic [TW-1:0] T_MAX = '1;
  // requested_mode 3 has no enum member; it must never pass an unverified calibration
  localparam logic [MODE_W-1:0] MODE_UNDEF = 2'd3;

  typedef struct {
    action_t           action;
    logic [TW-1:0]     stamp;
    logic              snapshot_ok;
    logic [MODE_W-1:0] mode;
  } sync_item_t;

  logic clk = 1'b0;
  logic rst;

  stsm_in_if #(.TIME_WIDTH(TW)) item_if ();
  stsm_out_if                   result_if ();
  stsm_cfg_if                   cfg_if ();

  sensor_timestamp_sync_monitor_top #(
    .TIME_WIDTH(TW)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the block's registers and source store, updated on each handshake.
  logic [THR_W-1:0]  tmo [N_SRC];
  logic [THR_W-1:0]  skew_warn_thr;
  logic [THR_W-1:0]  skew_pass_thr;
  logic              cal_verified;
  logic [MASK_W-1:0] allow_mask;
  logic [N_SRC-1:0]  src_present;
  logic [TW-1:0]     src_stamp [N_SRC];

  sync_item_t item_q [$];     // items waiting to be offered
  result_t    verdict_q [$];  // verdicts predicted for accepted items
  int         n_fail = 0;
  int         n_results = 0;

  // Work out the verdict for one item and apply its effect on the source store.
  function automatic result_t monitor_verdict(input sync_item_t it);
    result_t           r;
    logic [MASK_W-1:0] missing, stale, future, swarn, spass;
    logic [TW-1:0]     a, b, d;
    logic              passive, bp, bc;
    r = '0;
    if (it.action != ACT_EVAL) begin
      if (it.snapshot_ok) begin
        src_stamp[it.action]   = it.stamp;
        src_present[it.action] = 1'b1;
      end else begin
        r.rejected = 1'b1;
      end
      r.complete = &src_present;
      return r;
    end
    missing = ~src_present;
    stale   = '0;
    future  = '0;
    swarn   = '0;
    spass   = '0;
    for (int i = 0; i < N_SRC; i++) begin
      if (src_present[i]) begin
        // a stamp ahead of now is future and never also stale
        if (src_stamp[i] > it.stamp) future[i] = 1'b1;
        else if (it.stamp - src_stamp[i] > TW'(tmo[i])) stale[i] = 1'b1;
      end
    end
    if (&src_present) begin
      for (int p = 0; p < N_SRC; p++) begin
        a = src_stamp[PAIR_A[p]];
        b = src_stamp[PAIR_B[p]];
        d = (a >= b) ? a - b : b - a;
        if (d > TW'(skew_pass_thr)) spass[p] = 1'b1;
        else if (d > TW'(skew_warn_thr)) swarn[p] = 1'b1;
      end
    end
    passive = |(missing | stale | future | spass);
    bp = (it.mode == MODE_ACTIVE) && passive;
    if (cal_verified) bc = 1'b0;
    else if (it.mode == MODE_UNDEF) bc = 1'b1;
    else bc = !allow_mask[it.mode];
    r.severity               = passive ? SEV_PASSIVE : (|swarn ? SEV_WARN : SEV_OK);
    r.complete               = &src_present;
    r.missing_mask           = missing;
    r.stale_mask             = stale;
    r.future_mask            = future;
    r.skew_warn_mask         = swarn;
    r.skew_passive_mask      = spass;
    r.mode_granted           = !bp && !bc;
    r.blocked_by_passive     = bp;
    r.blocked_by_calibration = bc;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Item driver: offer queued items in bursts of random length with random gaps.
  // Hold an offered item until the block takes it; predict its verdict on accept.
  // ---------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    sync_item_t taken;
    if (rst) begin
      item_if.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (item_if.valid && item_if.ready) begin
        taken     = item_q.pop_front();
        verdict_q = {verdict_q, monitor_verdict(taken)};
        if (burst_left != 0) burst_left--;
      end
      if (!(item_if.valid && !item_if.ready)) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 24);
          // a quarter of the bursts follow on with no gap at all
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (gap_left != 0 || item_q.size() == 0) begin
          item_if.valid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end else begin
          item_if.valid          <= 1'b1;
          item_if.action         <= item_q[0].action;
          item_if.stamp_us       <= item_q[0].stamp;
          item_if.snapshot_ok    <= item_q[0].snapshot_ok;
          item_if.requested_mode <= item_q[0].mode;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each result with the oldest verdict, field by field.
  // Ready cycles through four moods, and twice drops for a long stretch so the block
  // backs up into its input.
  // ---------------------------------------------------------------------------
  int rcv_cyc;
  int hold_left;

  task automatic check_field(input string name, input logic [3:0] e, input logic [3:0] a);
    if (e !== a) begin
      n_fail++;
      if (n_fail <= 10)
        $display("mismatch on %s of result %0d: expected %0h, got %0h",
                 name, n_results, e, a);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_if.ready <= 1'b0;
      rcv_cyc   = 0;
      hold_left = 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        n_results++;
        if (verdict_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) $display("result %0d arrived with no item pending", n_results);
        end else begin
          want = verdict_q.pop_front();
          check_field("rejected", 4'(want.rejected), 4'(result_if.rejected));
          check_field("severity", 4'(want.severity), 4'(result_if.severity));
          check_field("complete", 4'(want.complete), 4'(result_if.complete));
          check_field("missing_mask", 4'(want.missing_mask), 4'(result_if.missing_mask));
          check_field("stale_mask", 4'(want.stale_mask), 4'(result_if.stale_mask));
          check_field("future_mask", 4'(want.future_mask), 4'(result_if.future_mask));
          check_field("skew_warn_mask", 4'(want.skew_warn_mask),
                      4'(result_if.skew_warn_mask));
          check_field("skew_passive_mask", 4'(want.skew_passive_mask),
                      4'(result_if.skew_passive_mask));
          check_field("mode_granted", 4'(want.mode_granted),
                      4'(result_if.mode_granted));
          check_field("blocked_by_passive", 4'(want.blocked_by_passive),
                      4'(result_if.blocked_by_passive));
          check_field("blocked_by_calibration", 4'(want.blocked_by_calibration),
                      4'(result_if.blocked_by_calibration));
        end
        // both points fall in the middle of a long phase, so the sender keeps going
        if (n_results == 100 || n_results == 460) hold_left = 200;
      end
      rcv_cyc++;
      if (hold_left != 0) begin
        result_if.ready <= 1'b0;
        hold_left--;
      end else begin
        case ((rcv_cyc / 97) % 4)
          0: result_if.ready <= 1'b1;
          1: result_if.ready <= ($urandom_range(0, 1) == 1);
          2: result_if.ready <= ($urandom_range(0, 3) == 0);
          default: result_if.ready <= rcv_cyc[0];
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic longint unsigned rand_upto(input longint unsigned span);
    if (span <= 64'hFFFF_FFFE) return 64'($urandom_range(0, 32'(span)));
    return {$urandom, $urandom} % (span + 1);
  endfunction

  task automatic add_item(input action_t act, input logic [TW-1:0] stamp,
                          input logic ok, input logic [MODE_W-1:0] mode);
    sync_item_t it;
    it.action      = act;
    it.stamp       = stamp;
    it.snapshot_ok = ok;
    it.mode        = mode;
    item_q = {item_q, it};
  endtask

  // Start at a rising edge; leave valid high so back-to-back writes need no dip.
  task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_JOINT_TIMEOUT: tmo[0]        = val;
      REG_ODOM_TIMEOUT:  tmo[1]        = val;
      REG_IMU_TIMEOUT:   tmo[2]        = val;
      REG_SKEW_WARN:     skew_warn_thr = val;
      REG_SKEW_PASSIVE:  skew_pass_thr = val;
      REG_CAL_VERIFIED:  cal_verified  = val[0];
      REG_ALLOW_MASK:    allow_mask    = val[MASK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_cfg(input logic [31:0] t0, t1, t2, warn, pass, cal, mask);
    cfg_write(REG_JOINT_TIMEOUT, t0);
    cfg_write(REG_ODOM_TIMEOUT, t1);
    cfg_write(REG_IMU_TIMEOUT, t2);
    cfg_write(REG_SKEW_WARN, warn);
    cfg_write(REG_SKEW_PASSIVE, pass);
    cfg_write(REG_CAL_VERIFIED, cal);
    cfg_write(REG_ALLOW_MASK, mask);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Hold the sender until every verdict is back, then let the pipe settle.
  // Returns at a rising edge so register writes can follow directly.
  task automatic drain();
    @(negedge clk);
    while (item_q.size() != 0 || verdict_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly well-formed traffic around a moving time base, aimed at the
  // timeout and skew boundaries of the current settings, plus some noise.
  task automatic gen_phase(input int n_items, input logic [TW-1:0] start);
    logic [TW-1:0]     base, s;
    logic [TW-1:0]     last [N_SRC];
    logic              ok;
    logic [MODE_W-1:0] mode;
    int unsigned       pick, src, other;
    longint unsigned   skew_span;
    base = start;
    for (int i = 0; i < N_SRC; i++) last[i] = start;
    skew_span = 64'(skew_pass_thr) * 2 + 2;
    for (int k = 0; k < n_items; k++) begin
      pick  = $urandom_range(0, 99);
      src   = $urandom_range(0, 2);
      other = (src + $urandom_range(1, 2)) % 3;
      mode  = ($urandom_range(0, 9) == 0) ? MODE_UNDEF : MODE_W'($urandom_range(0, 2));
      if (pick < 12) begin
        add_item(action_t'($urandom_range(0, 3)), TW'({$urandom, $urandom}),
                 1'($urandom_range(0, 1)), MODE_W'($urandom_range(0, 3)));
      end else if (pick < 58) begin
        case ($urandom_range(0, 3))
          0: s = last[other] + TW'(skew_warn_thr) + TW'($urandom_range(0, 1));
          1: s = last[other] - TW'(skew_pass_thr) - TW'($urandom_range(0, 1));
          default: s = base - TW'(rand_upto(skew_span));
        endcase
        ok = ($urandom_range(0, 7) != 0);
        if (ok) last[src] = s;
        add_item(action_t'(src), s, ok, mode);
      end else begin
        case ($urandom_range(0, 4))
          0: s = last[src] + TW'(tmo[src]);
          1: s = last[src] + TW'(tmo[src]) + 1'b1;
          2: s = last[src] - TW'($urandom_range(1, 3));
          default: s = base + TW'(rand_upto(64'(tmo[src])));
        endcase
        add_item(ACT_EVAL, s, 1'($urandom_range(0, 1)), mode);
        base = base + TW'(rand_upto(64'(skew_warn_thr) / 2 + 1));
      end
    end
  endtask

  initial begin
    rst                    = 1'b1;
    item_if.valid          = 1'b0;
    item_if.action         = ACT_JOINT;
    item_if.stamp_us       = '0;
    item_if.snapshot_ok    = 1'b0;
    item_if.requested_mode = MODE_DRY_RUN;
    result_if.ready        = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = REG_JOINT_TIMEOUT;
    cfg_if.data            = '0;
    for (int i = 0; i < N_SRC; i++) begin
      tmo[i]       = TIMEOUT_RESET;
      src_stamp[i] = '0;
    end
    skew_warn_thr = SKEW_WARN_RESET;
    skew_pass_thr = SKEW_PASSIVE_RESET;
    cal_verified  = 1'b0;
    allow_mask    = ALLOW_MASK_RESET;
    src_present   = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed pass on reset settings: warn 10000, passive 20000, timeouts 100000.
    add_item(ACT_EVAL, 48'd0, 1'b1, MODE_DRY_RUN);             // nothing received yet
    add_item(ACT_JOINT, 48'd0, 1'b0, MODE_ACTIVE);             // bad snapshot, dropped
    add_item(ACT_JOINT, 48'd1_000_000, 1'b1, MODE_SHADOW);
    add_item(ACT_EVAL, 48'd1_000_000, 1'b0, MODE_ACTIVE);      // two sources missing
    add_item(ACT_ODOM, 48'd1_010_000, 1'b1, MODE_DRY_RUN);     // skew exactly at warn
    add_item(ACT_IMU, 48'd1_020_001, 1'b1, MODE_UNDEF);        // one over passive
    add_item(ACT_EVAL, 48'd1_020_001, 1'b1, MODE_SHADOW);
    add_item(ACT_EVAL, 48'd1_100_000, 1'b1, MODE_ACTIVE);      // joint age at timeout
    add_item(ACT_EVAL, 48'd1_100_001, 1'b0, MODE_DRY_RUN);     // joint one past timeout
    add_item(ACT_EVAL, 48'd1_015_000, 1'b1, MODE_UNDEF);       // inertial from the future
    add_item(ACT_IMU, 48'd1_010_000, 1'b1, MODE_ACTIVE);
    add_item(ACT_EVAL, 48'd1_010_000, 1'b1, MODE_ACTIVE);      // clean, calibration blocks
    add_item(ACT_ODOM, 48'd1_010_001, 1'b1, MODE_SHADOW);      // one over warn
    add_item(ACT_EVAL, 48'd1_050_000, 1'b0, MODE_SHADOW);
    add_item(ACT_IMU, 48'd0, 1'b0, MODE_DRY_RUN);              // rejected once complete
    add_item(ACT_JOINT, T_MAX, 1'b1, MODE_ACTIVE);
    add_item(ACT_EVAL, T_MAX, 1'b1, MODE_ACTIVE);              // widest skews and ages
    add_item(ACT_ODOM, T_MAX, 1'b1, MODE_SHADOW);
    add_item(ACT_IMU, T_MAX, 1'b1, MODE_DRY_RUN);
    add_item(ACT_EVAL, T_MAX, 1'b0, MODE_DRY_RUN);             // all equal at the top
    add_item(ACT_EVAL, 48'd0, 1'b1, MODE_SHADOW);              // every stamp in the future
    gen_phase(130, 48'd2_000_000);

    // Verified calibration, widest thresholds.
    drain();
    set_cfg('1, '1, '1, '1, '1, 32'd1, 32'd0);
    gen_phase(130, TW'({$urandom, $urandom}));

    // Narrowest thresholds, every mode allowed; start close to the wrap point.
    drain();
    set_cfg(32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd0, 32'd7);
    gen_phase(130, T_MAX - TW'($urandom_range(0, 200)));

    // Warn above passive, nothing allowed; only bit 0 of the calibration data counts.
    drain();
    set_cfg(32'd30_000, 32'd5_000, 32'd200_000, 32'd50_000, 32'd20_000,
            32'hFFFF_FFFE, 32'hFFFF_FFF8);
    gen_phase(130, TW'({$urandom, $urandom}));

    // Random settings, passive mostly at or above warn.
    repeat (3) begin
      logic [31:0] warn;
      drain();
      warn = $urandom_range(1, 40_000);
      set_cfg($urandom_range(1, 300_000), $urandom_range(1, 300_000),
              $urandom_range(1, 300_000), warn,
              ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40_000)
                                          : warn + $urandom_range(0, 40_000),
              $urandom_range(0, 1), $urandom_range(0, 7));
      gen_phase(130, TW'({$urandom, $urandom}));
    end

    drain();
    repeat (10) @(posedge clk);
    if (n_fail == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Backstop against a hung handshake: far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
